[hw/rtl/evkbd_pkg.sv]
// Shared types, constants and the key code map for the key event to HID
// keyboard report converter. No dependencies.
package evkbd_pkg;

  // Input and output field widths
  localparam int CODE_W  = 10;
  localparam int VALUE_W = 2;
  localparam int USAGE_W = 8;
  localparam int ENTRY_W = 16;

  // Map size and report shape
  localparam int MAP_ENTRIES = 256;
  localparam int MAP_IDX_W   = $clog2(MAP_ENTRIES);
  localparam int OUT_SLOTS   = 6;

  // Command queue between the classifier and the report engine
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Key value codes
  localparam logic [VALUE_W-1:0] KEY_RELEASE = 2'd0;
  localparam logic [VALUE_W-1:0] KEY_PRESS   = 2'd1;

  // Map entry encoding: low byte usage, high byte modifier bit
  localparam logic [ENTRY_W-1:0] MOD_FIELD_MASK = 16'hFF00;
  localparam logic [ENTRY_W-1:0] M_LCTRL  = 16'h0100;
  localparam logic [ENTRY_W-1:0] M_LSHIFT = 16'h0200;
  localparam logic [ENTRY_W-1:0] M_LALT   = 16'h0400;
  localparam logic [ENTRY_W-1:0] M_LGUI   = 16'h0800;
  localparam logic [ENTRY_W-1:0] M_RCTRL  = 16'h1000;
  localparam logic [ENTRY_W-1:0] M_RSHIFT = 16'h2000;
  localparam logic [ENTRY_W-1:0] M_RALT   = 16'h4000;
  localparam logic [ENTRY_W-1:0] M_RGUI   = 16'h8000;

  // Classified key event handed from front to back
  typedef struct packed {
    logic               is_mod;  // data is a modifier bit mask
    logic               press;   // set on press, clear on release
    logic [USAGE_W-1:0] data;    // usage or modifier mask
  } evkbd_cmd_t;

  // Key code to HID usage or modifier map; zero means unmapped
  function automatic logic [ENTRY_W-1:0] evkbd_map_lookup(input logic [MAP_IDX_W-1:0] code);
    logic [ENTRY_W-1:0] e;
    case (code)
      8'd1:   e = 16'h0029;
      8'd2:   e = 16'h001e;
      8'd3:   e = 16'h001f;
      8'd4:   e = 16'h0020;
      8'd5:   e = 16'h0021;
      8'd6:   e = 16'h0022;
      8'd7:   e = 16'h0023;
      8'd8:   e = 16'h0024;
      8'd9:   e = 16'h0025;
      8'd10:  e = 16'h0026;
      8'd11:  e = 16'h0027;
      8'd12:  e = 16'h002D;
      8'd13:  e = 16'h002E;
      8'd14:  e = 16'h002A;
      8'd15:  e = 16'h002B;
      8'd16:  e = 16'h0014;
      8'd17:  e = 16'h001a;
      8'd18:  e = 16'h0008;
      8'd19:  e = 16'h0015;
      8'd20:  e = 16'h0017;
      8'd21:  e = 16'h001c;
      8'd22:  e = 16'h0018;
      8'd23:  e = 16'h000c;
      8'd24:  e = 16'h0012;
      8'd25:  e = 16'h0013;
      8'd26:  e = 16'h002F;
      8'd27:  e = 16'h0030;
      8'd28:  e = 16'h0028;
      8'd29:  e = M_LCTRL;
      8'd30:  e = 16'h0004;
      8'd31:  e = 16'h0016;
      8'd32:  e = 16'h0007;
      8'd33:  e = 16'h0009;
      8'd34:  e = 16'h000a;
      8'd35:  e = 16'h000b;
      8'd36:  e = 16'h000d;
      8'd37:  e = 16'h000e;
      8'd38:  e = 16'h000f;
      8'd39:  e = 16'h0033;
      8'd40:  e = 16'h0034;
      8'd41:  e = 16'h0035;
      8'd42:  e = M_LSHIFT;
      8'd43:  e = 16'h0031;
      8'd44:  e = 16'h001d;
      8'd45:  e = 16'h001b;
      8'd46:  e = 16'h0006;
      8'd47:  e = 16'h0019;
      8'd48:  e = 16'h0005;
      8'd49:  e = 16'h0011;
      8'd50:  e = 16'h0010;
      8'd51:  e = 16'h0036;
      8'd52:  e = 16'h0037;
      8'd53:  e = 16'h0038;
      8'd54:  e = M_RSHIFT;
      8'd55:  e = 16'h0055;
      8'd56:  e = M_LALT;
      8'd57:  e = 16'h002C;
      8'd58:  e = 16'h0039;
      8'd59:  e = 16'h003a;
      8'd60:  e = 16'h003b;
      8'd61:  e = 16'h003c;
      8'd62:  e = 16'h003d;
      8'd63:  e = 16'h003e;
      8'd64:  e = 16'h003f;
      8'd65:  e = 16'h0040;
      8'd66:  e = 16'h0041;
      8'd67:  e = 16'h0042;
      8'd68:  e = 16'h0043;
      8'd69:  e = 16'h0053;
      8'd70:  e = 16'h0047;
      8'd71:  e = 16'h005F;
      8'd72:  e = 16'h0060;
      8'd73:  e = 16'h0061;
      8'd74:  e = 16'h0056;
      8'd75:  e = 16'h005C;
      8'd76:  e = 16'h005D;
      8'd77:  e = 16'h005E;
      8'd78:  e = 16'h0057;
      8'd79:  e = 16'h0059;
      8'd80:  e = 16'h005A;
      8'd81:  e = 16'h005B;
      8'd82:  e = 16'h0062;
      8'd83:  e = 16'h0063;
      8'd87:  e = 16'h0044;
      8'd88:  e = 16'h0045;
      8'd96:  e = 16'h0028;
      8'd97:  e = M_RCTRL;
      8'd98:  e = 16'h0054;
      8'd100: e = M_RALT;
      8'd102: e = 16'h004A;
      8'd103: e = 16'h0052;
      8'd104: e = 16'h004B;
      8'd105: e = 16'h0050;
      8'd106: e = 16'h004F;
      8'd107: e = 16'h004D;
      8'd108: e = 16'h0051;
      8'd109: e = 16'h004E;
      8'd110: e = 16'h0049;
      8'd111: e = 16'h004C;
      8'd117: e = 16'h0067;
      8'd119: e = 16'h0048;
      8'd125: e = M_LGUI;
      8'd126: e = M_RGUI;
      8'd127: e = 16'h0065;
      8'd210: e = 16'h0046;
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

[hw/rtl/evkbd_if.sv]
// Valid/ready channel interfaces for key events and keyboard reports.
// Depends on evkbd_pkg.
interface evkbd_in_if;
  import evkbd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CODE_W-1:0]    key_code;
  logic [VALUE_W-1:0]   key_value;

  modport source (output valid, output key_code, output key_value, input ready);
  modport sink   (input valid, input key_code, input key_value, output ready);
endinterface

interface evkbd_out_if;
  import evkbd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [USAGE_W-1:0]   modifier_bits;
  logic [USAGE_W-1:0]   slot_zero;
  logic [USAGE_W-1:0]   slot_one;
  logic [USAGE_W-1:0]   slot_two;
  logic [USAGE_W-1:0]   slot_three;
  logic [USAGE_W-1:0]   slot_four;
  logic [USAGE_W-1:0]   slot_five;

  modport source (output valid, output modifier_bits, output slot_zero, output slot_one,
                  output slot_two, output slot_three, output slot_four, output slot_five,
                  input ready);
  modport sink   (input valid, input modifier_bits, input slot_zero, input slot_one,
                  input slot_two, input slot_three, input slot_four, input slot_five,
                  output ready);
endinterface

[hw/rtl/evkbd_to_hid_keyboard_report_top.sv]
// Top level of the key event to HID boot keyboard report converter.
// Depends on evkbd_pkg, evkbd_if, evkbd_front, evkbd_fifo and evkbd_back.
//
// Usage:
//   in_chan takes one key event per beat: a 10-bit key code and a 2-bit
//   value (0 release, 1 press, 2 autorepeat). out_chan delivers one
//   keyboard report per kept event: the modifier byte and six key slots,
//   packed in press order, zero where empty.
//   Events with a code past the map, an unmapped code or a value other
//   than press or release are consumed and give no report.
//   A report passes through the command queue and the output register
//   after its event is accepted, and is held until out_chan takes it.
//   in_chan takes one event per clock while the queue is not full.
//   A four-entry command queue sits between the classifier and the report
//   engine; when out_chan stalls, the queue fills and in_chan.ready drops
//   once it is full. Nothing is lost while the receiver stalls.
//   Reset clears the modifier byte, all key slots, the queue and the
//   output valid flag.
module evdev_to_hid_keyboard_report_top
  import evkbd_pkg::*;
#(
  parameter int SLOT_COUNT = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  evkbd_in_if.sink    in_chan,
  evkbd_out_if.source out_chan
);

  logic       front_valid;
  logic       front_ready;
  evkbd_cmd_t front_cmd;
  logic       back_valid;
  logic       back_ready;
  evkbd_cmd_t back_cmd;

  // Classify incoming events
  evkbd_front u_front (
    .in_chan   (in_chan),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  // Decouple front and back
  evkbd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_cmd    (back_cmd)
  );

  // Update key state and emit reports
  evkbd_back #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .cmd       (back_cmd),
    .out_chan  (out_chan)
  );

endmodule

[hw/rtl/evkbd_front.sv]
// Front end: accepts key events, looks up the key map and classifies them.
// Depends on evkbd_pkg and evkbd_in_if.
module evkbd_front
  import evkbd_pkg::*;
(
  evkbd_in_if.sink         in_chan,
  output logic             cmd_valid,
  input  logic             cmd_ready,
  output evkbd_cmd_t       cmd
);

  logic [ENTRY_W-1:0] entry;
  logic               in_range;
  logic               keep;

  // Look up the code; codes past the map are dropped
  assign in_range = (in_chan.key_code[CODE_W-1:MAP_IDX_W] == '0);
  assign entry    = evkbd_map_lookup(in_chan.key_code[MAP_IDX_W-1:0]);

  // Keep only mapped press and release events
  assign keep = in_range && (entry != '0)
              && ((in_chan.key_value == KEY_RELEASE) || (in_chan.key_value == KEY_PRESS));

  // Build the command for the report engine
  always_comb begin
    cmd.is_mod = ((entry & MOD_FIELD_MASK) != '0);
    cmd.press  = (in_chan.key_value == KEY_PRESS);
    cmd.data   = cmd.is_mod ? entry[ENTRY_W-1:USAGE_W] : entry[USAGE_W-1:0];
  end

  // Dropped events are consumed whenever the queue could take a beat
  assign cmd_valid     = in_chan.valid && keep;
  assign in_chan.ready = cmd_ready;

endmodule

[hw/rtl/evkbd_fifo.sv]
// Short command queue between the classifier and the report engine.
// Depends on evkbd_pkg.
module evkbd_fifo
  import evkbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  evkbd_cmd_t push_cmd,
  output logic       pop_valid,
  input  logic       pop_ready,
  output evkbd_cmd_t pop_cmd
);

  evkbd_cmd_t        entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic              push;
  logic              pop;

  assign push_ready = (count_r != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = entries_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Store the incoming beat
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

[hw/rtl/evkbd_back.sv]
// Back end: applies commands to the modifier byte and key slots and
// registers the report. Depends on evkbd_pkg and evkbd_out_if.
module evkbd_back
  import evkbd_pkg::*;
#(
  parameter int SLOT_COUNT = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  evkbd_cmd_t  cmd,
  evkbd_out_if.source out_chan
);

  logic [USAGE_W-1:0]    mod_r;
  logic [USAGE_W-1:0]    mod_nxt;
  logic [USAGE_W-1:0]    slots_r   [SLOT_COUNT];
  logic [USAGE_W-1:0]    slots_nxt [SLOT_COUNT];
  logic [USAGE_W-1:0]    slot_up   [SLOT_COUNT];
  logic [USAGE_W-1:0]    view      [OUT_SLOTS];
  logic [SLOT_COUNT-1:0] hit;
  logic [SLOT_COUNT-1:0] hit_pre;
  logic [SLOT_COUNT-1:0] free;
  logic [SLOT_COUNT-1:0] first_free;
  logic                  out_valid_r;
  logic [USAGE_W-1:0]    out_mod_r;
  logic [USAGE_W-1:0]    out_slot_r [OUT_SLOTS];
  logic                  pop;

  // Take a command whenever the output register is free or being drained
  assign cmd_ready = !out_valid_r || out_chan.ready;
  assign pop       = cmd_valid && cmd_ready;

  // Compare the usage against every slot; slots are always packed
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      hit[i]  = (slots_r[i] == cmd.data);
      free[i] = (slots_r[i] == '0);
    end
    hit_pre[0] = hit[0];
    for (int i = 1; i < SLOT_COUNT; i++) begin
      hit_pre[i] = hit_pre[i-1] | hit[i];
    end
  end

  // Neighbor views: first free slot and the slot above for compaction
  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_slot
    if (g == 0) begin : g_first
      assign first_free[g] = free[g];
    end else begin : g_rest
      assign first_free[g] = free[g] && !free[g-1];
    end
    if (g < SLOT_COUNT - 1) begin : g_up
      assign slot_up[g] = slots_r[g+1];
    end else begin : g_top
      assign slot_up[g] = '0;
    end
  end

  // Apply the command: modifier set or clear, key insert or remove
  always_comb begin
    mod_nxt = mod_r;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slots_nxt[i] = slots_r[i];
    end
    if (cmd.is_mod) begin
      mod_nxt = cmd.press ? (mod_r | cmd.data) : (mod_r & ~cmd.data);
    end else if (cmd.press) begin
      if (hit == '0) begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (first_free[i]) begin
            slots_nxt[i] = cmd.data;
          end
        end
      end
    end else begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (hit_pre[i]) begin
          slots_nxt[i] = slot_up[i];
        end
      end
    end
  end

  // Report shows the first six slots, zero past the slot count
  for (genvar k = 0; k < OUT_SLOTS; k++) begin : g_view
    if (k < SLOT_COUNT) begin : g_shown
      assign view[k] = slots_nxt[k];
    end else begin : g_blank
      assign view[k] = '0;
    end
  end

  // Hold key state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slots_r[i] <= '0;
      end
    end else if (pop) begin
      mod_r <= mod_nxt;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slots_r[i] <= slots_nxt[i];
      end
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (pop) begin
      out_mod_r <= mod_nxt;
      for (int k = 0; k < OUT_SLOTS; k++) begin
        out_slot_r[k] <= view[k];
      end
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.modifier_bits = out_mod_r;
  assign out_chan.slot_zero     = out_slot_r[0];
  assign out_chan.slot_one      = out_slot_r[1];
  assign out_chan.slot_two      = out_slot_r[2];
  assign out_chan.slot_three    = out_slot_r[3];
  assign out_chan.slot_four     = out_slot_r[4];
  assign out_chan.slot_five     = out_slot_r[5];

endmodule

[verif/tb_top.sv]
// Testbench for the key event to HID keyboard report converter: directed rows, then
// random key traffic, checked beat by beat against a local model of the slot logic.
// Depends on evkbd_pkg, evkbd_if and evdev_to_hid_keyboard_report_top.
`timescale 1ns / 100ps

module tb_top;
  import evkbd_pkg::*;

  localparam int CLK_PERIOD       = 12;
  localparam int RESET_CYCLES     = 2;
  localparam int SLOT_COUNT       = 6;
  localparam int RANDOM_PER_PHASE = 476;
  localparam int POOL_KEYS        = 9;
  localparam int POOL_REFRESH     = 48;
  localparam int LONG_HOLD_CYCLES = 60;
  localparam int DRAIN_CYCLES     = 8;
  localparam int QUIET_LIMIT      = 3000;

  // Key values the package leaves unnamed
  localparam logic [VALUE_W-1:0] KEY_REPEAT = 2'd2;
  localparam logic [VALUE_W-1:0] KEY_SPARE  = 2'd3;

  // Key codes used by the directed rows
  localparam logic [CODE_W-1:0] KC_RESERVED   = 10'd0;
  localparam logic [CODE_W-1:0] KC_LEFTCTRL   = 10'd29;
  localparam logic [CODE_W-1:0] KC_A          = 10'd30;
  localparam logic [CODE_W-1:0] KC_D          = 10'd32;
  localparam logic [CODE_W-1:0] KC_F          = 10'd33;
  localparam logic [CODE_W-1:0] KC_E          = 10'd18;
  localparam logic [CODE_W-1:0] KC_C          = 10'd46;
  localparam logic [CODE_W-1:0] KC_B          = 10'd48;
  localparam logic [CODE_W-1:0] KC_RIGHTMETA  = 10'd126;
  localparam logic [CODE_W-1:0] KC_COMPOSE    = 10'd127;
  localparam logic [CODE_W-1:0] KC_SCROLLLOCK = 10'd210;
  localparam logic [CODE_W-1:0] KC_LAST_ROM   = 10'd255;
  localparam logic [CODE_W-1:0] KC_PAST_ROM   = 10'd256;
  localparam logic [CODE_W-1:0] KC_MAX        = 10'h3FF;

  // Lower half of the key map; everything above is unmapped but scroll lock
  localparam logic [ENTRY_W-1:0] KEYMAP_LOW [0:127] = '{
    16'h00, 16'h29, 16'h1e, 16'h1f, 16'h20, 16'h21, 16'h22, 16'h23,
    16'h24, 16'h25, 16'h26, 16'h27, 16'h2D, 16'h2E, 16'h2A, 16'h2B,
    16'h14, 16'h1a, 16'h08, 16'h15, 16'h17, 16'h1c, 16'h18, 16'h0c,
    16'h12, 16'h13, 16'h2F, 16'h30, 16'h28, M_LCTRL, 16'h04, 16'h16,
    16'h07, 16'h09, 16'h0a, 16'h0b, 16'h0d, 16'h0e, 16'h0f, 16'h33,
    16'h34, 16'h35, M_LSHIFT, 16'h31, 16'h1d, 16'h1b, 16'h06, 16'h19,
    16'h05, 16'h11, 16'h10, 16'h36, 16'h37, 16'h38, M_RSHIFT, 16'h55,
    M_LALT, 16'h2C, 16'h39, 16'h3a, 16'h3b, 16'h3c, 16'h3d, 16'h3e,
    16'h3f, 16'h40, 16'h41, 16'h42, 16'h43, 16'h53, 16'h47, 16'h5F,
    16'h60, 16'h61, 16'h56, 16'h5C, 16'h5D, 16'h5E, 16'h57, 16'h59,
    16'h5A, 16'h5B, 16'h62, 16'h63, 16'h00, 16'h00, 16'h00, 16'h44,
    16'h45, 16'h00, 16'h00, 16'h00, 16'h00, 16'h00, 16'h00, 16'h00,
    16'h28, M_RCTRL, 16'h54, 16'h00, M_RALT, 16'h00, 16'h4A, 16'h52,
    16'h4B, 16'h50, 16'h4F, 16'h4D, 16'h51, 16'h4E, 16'h49, 16'h4C,
    16'h00, 16'h00, 16'h00, 16'h00, 16'h00, 16'h67, 16'h00, 16'h48,
    16'h00, 16'h00, 16'h00, 16'h00, 16'h00, M_LGUI, M_RGUI, 16'h65
  };
  localparam logic [ENTRY_W-1:0] SCROLLLOCK_ENTRY = 16'h0046;

  typedef struct packed {
    logic [USAGE_W-1:0] mods;
    logic [USAGE_W-1:0] slot0;
    logic [USAGE_W-1:0] slot1;
    logic [USAGE_W-1:0] slot2;
    logic [USAGE_W-1:0] slot3;
    logic [USAGE_W-1:0] slot4;
    logic [USAGE_W-1:0] slot5;
  } report_t;

  localparam int REPORT_FIELDS = 7;

  typedef enum logic [1:0] {
    CHK_NONE,   // event is consumed without a report
    CHK_TYPED,  // report given in the row
    CHK_MODEL   // report taken from the slot model
  } row_check_t;

  typedef struct {
    logic [CODE_W-1:0]  code;
    logic [VALUE_W-1:0] value;
    row_check_t         chk;
    report_t            rpt;
  } key_row_t;

  logic clk;
  logic rst_n;

  evkbd_in_if  in_if ();
  evkbd_out_if out_if ();

  evdev_to_hid_keyboard_report_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // Model state of the keyboard
  logic [USAGE_W-1:0] held_mods;
  logic [USAGE_W-1:0] held_keys [SLOT_COUNT];

  report_t  pending_reports [$];
  key_row_t directed_rows [$];
  logic [CODE_W-1:0] mapped_codes [$];
  int  mismatch_count = 0;
  int  source_idle_pct;
  int  sink_idle_pct;
  bit  hold_off_req = 1'b0;

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic [ENTRY_W-1:0] keymap_entry(input logic [CODE_W-1:0] code);
    if (code < 10'd128) begin
      return KEYMAP_LOW[code[6:0]];
    end
    if (code == KC_SCROLLLOCK) begin
      return SCROLLLOCK_ENTRY;
    end
    return '0;
  endfunction

  // Apply one key event to the model; report whether it produces a report
  task automatic advance_keyboard_state(input logic [CODE_W-1:0] code,
                                        input logic [VALUE_W-1:0] value,
                                        output bit emits, output report_t rpt);
    logic [ENTRY_W-1:0] entry;
    logic [USAGE_W-1:0] usage;
    logic [USAGE_W-1:0] packed_keys [SLOT_COUNT];
    bit held;
    bit placed;
    int w;
    emits = 1'b0;
    rpt   = '0;
    entry = keymap_entry(code);
    if (entry == '0 || value > KEY_PRESS) begin
      return;
    end
    if ((entry & MOD_FIELD_MASK) != '0) begin
      if (value == KEY_PRESS) begin
        held_mods = held_mods | entry[15:8];
      end else begin
        held_mods = held_mods & ~entry[15:8];
      end
    end else begin
      usage = entry[USAGE_W-1:0];
      if (value == KEY_PRESS) begin
        held = 1'b0;
        placed = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (held_keys[i] == usage) held = 1'b1;
        end
        // take the first free slot; drop the key when none is left
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (!held && !placed && held_keys[i] == '0) begin
            held_keys[i] = usage;
            placed = 1'b1;
          end
        end
      end else begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (held_keys[i] == usage) held_keys[i] = '0;
        end
      end
      // pack held keys to the front, keeping press order
      w = 0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        packed_keys[i] = '0;
      end
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (held_keys[i] != '0) begin
          packed_keys[w] = held_keys[i];
          w++;
        end
      end
      for (int i = 0; i < SLOT_COUNT; i++) begin
        held_keys[i] = packed_keys[i];
      end
    end
    emits = 1'b1;
    rpt = {held_mods, held_keys[0], held_keys[1], held_keys[2],
           held_keys[3], held_keys[4], held_keys[5]};
  endtask

  task automatic add_row(input logic [CODE_W-1:0] code, input logic [VALUE_W-1:0] value,
                         input row_check_t chk, input report_t rpt);
    key_row_t row;
    row.code  = code;
    row.value = value;
    row.chk   = chk;
    row.rpt   = rpt;
    directed_rows.push_back(row);
  endtask

  // Offer one event, wait for its beat, then record what it should produce
  task automatic send_key_event(input logic [CODE_W-1:0] code,
                                input logic [VALUE_W-1:0] value,
                                input row_check_t chk, input report_t typed);
    bit emits;
    report_t predicted;
    while ($urandom_range(99) < source_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.key_code  <= code;
    in_if.key_value <= value;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    advance_keyboard_state(code, value, emits, predicted);
    if (emits && chk != CHK_NONE) begin
      pending_reports.push_back(chk == CHK_TYPED ? typed : predicted);
    end
  endtask

  // Hold the input until every outstanding report has been taken
  task automatic drain_reports();
    in_if.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  // Receiver: random ready, with one long hold-off on request
  initial begin : report_sink
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req <= 1'b0;
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end
      out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Compare each report beat with the oldest expectation
  always @(posedge clk) begin : report_check
    report_t seen;
    report_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      seen = {out_if.modifier_bits, out_if.slot_zero, out_if.slot_one, out_if.slot_two,
              out_if.slot_three, out_if.slot_four, out_if.slot_five};
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected report %014h", $time, seen);
        mismatch_count++;
      end else begin
        want = pending_reports.pop_front();
        // field 0 is the modifier byte, fields 1..6 the key slots
        for (int f = 0; f < REPORT_FIELDS; f++) begin
          if (want[55 - 8 * f -: 8] !== seen[55 - 8 * f -: 8]) begin
            $display("%0t: report field %0d expected %02h got %02h", $time, f,
                     want[55 - 8 * f -: 8], seen[55 - 8 * f -: 8]);
            mismatch_count++;
          end
        end
      end
    end
  end

  // End the run when no beat moves on either channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [CODE_W-1:0]  key_pool [POOL_KEYS];
    logic [CODE_W-1:0]  code;
    logic [VALUE_W-1:0] value;
    int src_pct [3];
    int snk_pct [3];
    rst_n           <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.key_code  <= '0;
    in_if.key_value <= '0;
    held_mods = '0;
    for (int i = 0; i < SLOT_COUNT; i++) held_keys[i] = '0;
    src_pct = '{26, 74, 0};
    snk_pct = '{74, 26, 0};
    source_idle_pct = src_pct[0];
    sink_idle_pct   = snk_pct[0];
    for (int c = 0; c < MAP_ENTRIES; c++) begin
      if (keymap_entry(c[CODE_W-1:0]) != '0) mapped_codes.push_back(c[CODE_W-1:0]);
    end

    // Directed rows: reset state, dropped events, modifiers, full slots, packing
    add_row(KC_A,          KEY_RELEASE,  CHK_TYPED, 56'h00_00_00_00_00_00_00);
    add_row(KC_RESERVED,   KEY_PRESS,    CHK_NONE,  '0);
    add_row(KC_MAX,        KEY_PRESS,    CHK_NONE,  '0);
    add_row(KC_PAST_ROM,   KEY_PRESS,    CHK_NONE,  '0);
    add_row(KC_LAST_ROM,   KEY_PRESS,    CHK_NONE,  '0);
    add_row(KC_A,          KEY_REPEAT,   CHK_NONE,  '0);
    add_row(KC_A,          KEY_SPARE,    CHK_NONE,  '0);
    add_row(KC_LEFTCTRL,   KEY_PRESS,    CHK_TYPED, 56'h01_00_00_00_00_00_00);
    add_row(KC_RIGHTMETA,  KEY_PRESS,    CHK_TYPED, 56'h81_00_00_00_00_00_00);
    add_row(KC_A,          KEY_PRESS,    CHK_TYPED, 56'h81_04_00_00_00_00_00);
    add_row(KC_A,          KEY_PRESS,    CHK_TYPED, 56'h81_04_00_00_00_00_00);
    add_row(KC_B,          KEY_PRESS,    CHK_MODEL, '0);
    add_row(KC_C,          KEY_PRESS,    CHK_MODEL, '0);
    add_row(KC_D,          KEY_PRESS,    CHK_MODEL, '0);
    add_row(KC_E,          KEY_PRESS,    CHK_MODEL, '0);
    add_row(KC_F,          KEY_PRESS,    CHK_MODEL, '0);
    add_row(KC_SCROLLLOCK, KEY_PRESS,    CHK_MODEL, '0);
    add_row(KC_C,          KEY_RELEASE,  CHK_MODEL, '0);
    add_row(KC_SCROLLLOCK, KEY_PRESS,    CHK_MODEL, '0);
    add_row(KC_COMPOSE,    KEY_PRESS,    CHK_MODEL, '0);
    add_row(KC_LEFTCTRL,   KEY_RELEASE,  CHK_MODEL, '0);
    add_row(KC_RIGHTMETA,  KEY_RELEASE,  CHK_MODEL, '0);
    add_row(KC_A,          KEY_RELEASE,  CHK_MODEL, '0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      send_key_event(directed_rows[r].code, directed_rows[r].value,
                     directed_rows[r].chk, directed_rows[r].rpt);
    end
    drain_reports();

    // Random key traffic: a small pool of keys so slots fill and empty often
    for (int phase = 0; phase < 3; phase++) begin
      source_idle_pct = src_pct[phase];
      sink_idle_pct   = snk_pct[phase];
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (n % POOL_REFRESH == 0) begin
          foreach (key_pool[k]) begin
            key_pool[k] = mapped_codes[$urandom_range(mapped_codes.size() - 1)];
          end
        end
        if (phase == 2 && n == 100) hold_off_req <= 1'b1;
        if ($urandom_range(99) < 8) begin
          // noise: any code, any value
          code  = CODE_W'($urandom_range(KC_MAX));
          value = VALUE_W'($urandom_range(3));
        end else begin
          code  = key_pool[$urandom_range(POOL_KEYS - 1)];
          value = ($urandom_range(99) < 55) ? KEY_PRESS : KEY_RELEASE;
        end
        send_key_event(code, value, CHK_MODEL, '0);
      end
      drain_reports();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_reports.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/evkbd_pkg.sv
hw/rtl/evkbd_if.sv
hw/rtl/evkbd_front.sv
hw/rtl/evkbd_fifo.sv
hw/rtl/evkbd_back.sv
hw/rtl/evkbd_to_hid_keyboard_report_top.sv
verif/tb_top.sv
